FILE: design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RASC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rasc assertion failed");

// expression must never be true outside reset
`define RASC_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (!(expr))) \
    else $error("rasc forbidden condition seen");

`endif

FILE: design/rasc_pkg.sv
// shared types and constants for the relay alarm scheduler clock
// no dependencies
`default_nettype none

package rasc_pkg;

  // sizes and limits
  localparam int ENTRIES_PER_RELAY_DEF = 5;
  localparam int ENTRY_W               = 13;
  localparam int MIN_PER_HOUR          = 60;
  localparam logic [4:0]  HOUR_MAX     = 5'd23;
  localparam logic [5:0]  MINSEC_MAX   = 6'd59;
  localparam logic [10:0] MIN_PER_DAY  = 11'd1440;

  // clock values after reset
  localparam logic [4:0] HOUR_RST   = 5'd19;
  localparam logic [5:0] MINUTE_RST = 6'd30;
  localparam logic [5:0] SECOND_RST = 6'd0;

  // transaction modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // entry actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ON   = 2'd1;
  localparam logic [1:0] ACT_OFF  = 2'd2;
  localparam logic [1:0] ACT_BAD  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic       relay_select;
    logic [2:0] entry_index;
    logic [1:0] entry_action;
    logic [4:0] set_hour;
    logic [5:0] set_minute;
    logic [5:0] set_second;
  } in_t;

  typedef struct packed {
    logic        relay_one_on;
    logic        relay_two_on;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [5:0]  clock_second;
    logic        next_found;
    logic [2:0]  next_index;
    logic [4:0]  next_hour;
    logic [5:0]  next_minute;
    logic [10:0] next_wait;
  } out_t;

endpackage

`default_nettype wire

FILE: design/relay_alarm_scheduler_clock.sv
// time-of-day clock with a per-relay switching table held in a synchronous memory
// depends on rasc_pkg
//
//   channel  | signals                 | handshake
//   ---------+-------------------------+------------------------------------
//   command  | item (rasc_pkg::in_t)   | taken when start is high, busy low
//   result   | result (rasc_pkg::out_t)| valid for one cycle while done high
//
// each transaction first updates the clock or writes the table in the exec state,
// then issues one table read per cycle over all entries of both relays through the
// single memory read port, then drains the read and wait pipeline before done.
// busy stays high from accept until the result cycle; the table reads as
// cleared after reset through per-entry valid bits, so there is no clear pass.
`default_nettype none

module relay_alarm_scheduler_clock #(
  parameter int ENTRIES_PER_RELAY = rasc_pkg::ENTRIES_PER_RELAY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rasc_pkg::in_t  item,
  output logic           busy,
  output logic           done,
  output rasc_pkg::out_t result
);
  import rasc_pkg::*;

  localparam int TABLE_N = 2 * ENTRIES_PER_RELAY;
  localparam int ADDR_W  = $clog2(TABLE_N);
  localparam int IDX_W   = (ENTRIES_PER_RELAY > 1) ? $clog2(ENTRIES_PER_RELAY) : 1;
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(ENTRIES_PER_RELAY - 1);
  localparam logic [ADDR_W-1:0] REL_BASE = ADDR_W'(ENTRIES_PER_RELAY);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DRAIN} state_t;

  state_t state;
  in_t    q;

  // clock and relay state
  logic [4:0]  hour_count;
  logic [5:0]  minute_count;
  logic [5:0]  second_count;
  logic        relay_one_state;
  logic        relay_two_state;
  logic [10:0] now_min;

  // table memory with valid bits standing in for the cleared reset state
  logic [ENTRY_W-1:0] entry_mem [TABLE_N];
  logic [TABLE_N-1:0] entry_vld;
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_vld;

  // scan counters
  logic             scan_relay;
  logic [IDX_W-1:0] scan_idx;
  logic [ADDR_W-1:0] rd_addr;

  // pipeline stage 1: memory data
  logic             v1;
  logic             p1_relay;
  logic [IDX_W-1:0] p1_idx;

  // pipeline stage 2: entry time in minutes
  logic             v2;
  logic [10:0]      t_min;
  logic [IDX_W-1:0] p2_idx;
  logic [4:0]       p2_hour;
  logic [5:0]       p2_minute;

  // soonest pending entry so far
  logic             best_found;
  logic [10:0]      best_wait;
  logic [IDX_W-1:0] best_idx;
  logic [4:0]       best_hour;
  logic [5:0]       best_minute;

  // combinational helpers
  logic [4:0]         sat_hour;
  logic [5:0]         sat_minute;
  logic [5:0]         sat_second;
  logic [1:0]         wr_act;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [6:0]         sec_inc;
  logic [6:0]         min_inc;
  logic [5:0]         hour_inc;
  logic [4:0]         tick_hour;
  logic [5:0]         tick_minute;
  logic [5:0]         tick_second;
  logic [ENTRY_W-1:0] ent;
  logic [4:0]         ent_hour;
  logic [5:0]         ent_minute;
  logic [1:0]         ent_act;
  logic               ent_match;
  logic [11:0]        wait_sum;
  logic [10:0]        wait_min;
  logic               last_issue;

  assign busy = (state != S_IDLE);

  // input saturation and entry encoding
  always_comb begin
    sat_hour   = (q.set_hour > HOUR_MAX) ? HOUR_MAX : q.set_hour;
    sat_minute = (q.set_minute > MINSEC_MAX) ? MINSEC_MAX : q.set_minute;
    sat_second = (q.set_second > MINSEC_MAX) ? MINSEC_MAX : q.set_second;
    wr_act     = (q.entry_action == ACT_BAD) ? ACT_NONE : q.entry_action;
    wr_idx     = IDX_W'(q.entry_index);
    wr_addr    = q.relay_select ? (REL_BASE + ADDR_W'(wr_idx)) : ADDR_W'(wr_idx);
    wr_data    = {sat_hour, sat_minute, wr_act};
    wr_en      = (state == S_EXEC) && (q.mode == MODE_WRITE) &&
                 (int'(q.entry_index) < ENTRIES_PER_RELAY);
  end

  // one-second advance with wrap
  always_comb begin
    sec_inc     = 7'(second_count) + 7'd1;
    min_inc     = 7'(minute_count);
    hour_inc    = 6'(hour_count);
    tick_second = sec_inc[5:0];
    if (sec_inc > 7'(MINSEC_MAX)) begin
      tick_second = 6'd0;
      min_inc     = min_inc + 7'd1;
    end
    tick_minute = min_inc[5:0];
    if (min_inc > 7'(MINSEC_MAX)) begin
      tick_minute = 6'd0;
      hour_inc    = hour_inc + 6'd1;
    end
    tick_hour = hour_inc[4:0];
    if (hour_inc > 6'(HOUR_MAX)) begin
      tick_hour = 5'd0;
    end
  end

  // scan address and entry decode
  always_comb begin
    rd_addr    = scan_relay ? (REL_BASE + ADDR_W'(scan_idx)) : ADDR_W'(scan_idx);
    last_issue = scan_relay && (scan_idx == IDX_LAST);
    ent        = rd_vld ? rd_data : '0;
    ent_hour   = ent[12:8];
    ent_minute = ent[7:2];
    ent_act    = ent[1:0];
    ent_match  = (ent_hour == hour_count) && (ent_minute == minute_count);
    wait_sum   = 12'(t_min) + 12'(MIN_PER_DAY) - 12'(now_min);
    wait_min   = (wait_sum >= 12'(MIN_PER_DAY)) ? 11'(wait_sum - 12'(MIN_PER_DAY))
                                                : 11'(wait_sum);
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    rd_data <= entry_mem[rd_addr];
    rd_vld  <= entry_vld[rd_addr];
  end

  // sequencer, clock, relays and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      hour_count      <= HOUR_RST;
      minute_count    <= MINUTE_RST;
      second_count    <= SECOND_RST;
      relay_one_state <= 1'b0;
      relay_two_state <= 1'b0;
      entry_vld       <= '0;
      v1              <= 1'b0;
      v2              <= 1'b0;
    end else begin
      done    <= (state == S_DRAIN) && !v1 && !v2;
      now_min <= 11'(hour_count) * 11'(MIN_PER_HOUR) + 11'(minute_count);

      // stage 1: apply matching entries on ticks, pass selected entries on
      v1       <= (state == S_SCAN);
      p1_relay <= scan_relay;
      p1_idx   <= scan_idx;
      v2       <= v1 && (p1_relay == q.relay_select) && (ent_act != ACT_NONE);
      t_min    <= 11'(ent_hour) * 11'(MIN_PER_HOUR) + 11'(ent_minute);
      p2_idx    <= p1_idx;
      p2_hour   <= ent_hour;
      p2_minute <= ent_minute;
      if (v1 && (q.mode == MODE_TICK) && ent_match) begin
        if (ent_act == ACT_ON || ent_act == ACT_OFF) begin
          if (p1_relay) begin
            relay_two_state <= (ent_act == ACT_ON);
          end else begin
            relay_one_state <= (ent_act == ACT_ON);
          end
        end
      end

      // stage 2: keep the soonest entry, first index wins ties
      if (v2 && (wait_min < best_wait)) begin
        best_found  <= 1'b1;
        best_wait   <= wait_min;
        best_idx    <= p2_idx;
        best_hour   <= p2_hour;
        best_minute <= p2_minute;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            q     <= item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (q.mode)
            MODE_TICK: begin
              hour_count   <= tick_hour;
              minute_count <= tick_minute;
              second_count <= tick_second;
            end
            MODE_SET: begin
              hour_count   <= sat_hour;
              minute_count <= sat_minute;
              second_count <= sat_second;
            end
            MODE_WRITE: begin
              if (wr_en) begin
                entry_vld[wr_addr] <= 1'b1;
              end
            end
            MODE_QUERY: begin
            end
            default: begin
            end
          endcase
          scan_relay  <= 1'b0;
          scan_idx    <= '0;
          best_found  <= 1'b0;
          best_wait   <= MIN_PER_DAY;
          best_idx    <= '0;
          best_hour   <= '0;
          best_minute <= '0;
          state       <= S_SCAN;
        end
        S_SCAN: begin
          if (last_issue) begin
            state <= S_DRAIN;
          end else if (scan_idx == IDX_LAST) begin
            scan_idx   <= '0;
            scan_relay <= 1'b1;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            result.relay_one_on <= relay_one_state;
            result.relay_two_on <= relay_two_state;
            result.clock_hour   <= hour_count;
            result.clock_minute <= minute_count;
            result.clock_second <= second_count;
            result.next_found   <= best_found;
            result.next_index   <= 3'(best_idx);
            result.next_hour    <= best_hour;
            result.next_minute  <= best_minute;
            result.next_wait    <= best_found ? best_wait : 11'd0;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/rasc_checker.sv
// port-level checks for the relay alarm scheduler clock, bound to the top level
// depends on rasc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rasc_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire rasc_pkg::out_t result
);
  import rasc_pkg::*;

  logic accepted;
  logic idle_strobe_bad;
  logic empty_result_bad;
  logic clock_range_bad;

  assign accepted         = start && !busy;
  assign idle_strobe_bad  = done && busy;
  assign empty_result_bad = done && !result.next_found &&
                            (result.next_index != 3'd0 || result.next_hour != 5'd0 ||
                             result.next_minute != 6'd0 || result.next_wait != 11'd0);
  assign clock_range_bad  = done && (result.clock_hour > HOUR_MAX ||
                                     result.clock_minute > MINSEC_MAX ||
                                     result.clock_second > MINSEC_MAX ||
                                     result.next_wait >= MIN_PER_DAY);

  // an accepted transaction keeps the block busy on the next cycle
  `RASC_ASSERT(a_accept_busy, clk, rst, accepted |=> busy && !done)
  // a result strobe lasts one cycle per transaction
  `RASC_ASSERT(a_done_pulse, clk, rst, done |=> !done)
  // the result appears only once the block is free again
  `RASC_NEVER(a_done_while_busy, clk, rst, idle_strobe_bad)
  // with no pending entry the entry fields read zero
  `RASC_NEVER(a_empty_result, clk, rst, empty_result_bad)
  // reported times stay within a day
  `RASC_NEVER(a_clock_range, clk, rst, clock_range_bad)

endmodule

bind relay_alarm_scheduler_clock rasc_checker u_rasc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

FILE: tb/sv/relay_alarm_scheduler_clock_test.sv
// self-checking testbench for relay_alarm_scheduler_clock: directed and random transactions
// with a scoreboard class that predicts every result; depends on rasc_pkg and the design
`default_nettype none

module relay_alarm_scheduler_clock_test;
  import rasc_pkg::*;

  localparam int N_PER_RELAY = ENTRIES_PER_RELAY_DEF;
  localparam int TABLE_LEN   = 2 * N_PER_RELAY;
  localparam int ITEM_GOAL   = 1100;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [1:0] action;
  } sched_entry_t;

  // clock and switching table model plus the queue of predicted reports
  class alarm_scoreboard;
    logic [4:0]   clk_hour;
    logic [5:0]   clk_minute;
    logic [5:0]   clk_second;
    logic         relay_on [2];
    sched_entry_t sched [TABLE_LEN];
    out_t         pending_reports [$];
    int           error_count;

    function new();
      clk_hour    = HOUR_RST;
      clk_minute  = MINUTE_RST;
      clk_second  = SECOND_RST;
      relay_on[0] = 1'b0;
      relay_on[1] = 1'b0;
      foreach (sched[i]) sched[i] = '0;
      error_count = 0;
    endfunction

    // apply one accepted command and queue the report it must produce
    function void note_command(in_t cmd);
      logic [4:0]   hr_sat;
      logic [5:0]   mn_sat;
      logic [5:0]   sc_sat;
      logic [1:0]   act;
      sched_entry_t e;
      int           now_min;
      int           t_min;
      int           w;
      int           best_wait;
      int           best_idx;
      bit           found;
      out_t         rep;
      hr_sat = (cmd.set_hour > HOUR_MAX) ? HOUR_MAX : cmd.set_hour;
      mn_sat = (cmd.set_minute > MINSEC_MAX) ? MINSEC_MAX : cmd.set_minute;
      sc_sat = (cmd.set_second > MINSEC_MAX) ? MINSEC_MAX : cmd.set_second;
      case (cmd.mode)
        MODE_TICK: begin
          clk_second = clk_second + 6'd1;
          if (clk_second > MINSEC_MAX) begin
            clk_second = '0;
            clk_minute = clk_minute + 6'd1;
          end
          if (clk_minute > MINSEC_MAX) begin
            clk_minute = '0;
            clk_hour   = clk_hour + 5'd1;
          end
          if (clk_hour > HOUR_MAX) clk_hour = '0;
          // every matching entry acts in index order, so the last one wins
          for (int r = 0; r < 2; r++) begin
            for (int i = 0; i < N_PER_RELAY; i++) begin
              e = sched[r * N_PER_RELAY + i];
              if (e.hour == clk_hour && e.minute == clk_minute) begin
                if (e.action == ACT_ON) relay_on[r] = 1'b1;
                else if (e.action == ACT_OFF) relay_on[r] = 1'b0;
              end
            end
          end
        end
        MODE_SET: begin
          clk_hour   = hr_sat;
          clk_minute = mn_sat;
          clk_second = sc_sat;
        end
        MODE_WRITE: begin
          if (cmd.entry_index < N_PER_RELAY) begin
            act = (cmd.entry_action == ACT_BAD) ? ACT_NONE : cmd.entry_action;
            sched[cmd.relay_select * N_PER_RELAY + cmd.entry_index] = '{hr_sat, mn_sat, act};
          end
        end
        default: ;
      endcase

      // soonest pending entry of the selected relay, lowest index on ties
      now_min   = clk_hour * MIN_PER_HOUR + clk_minute;
      best_wait = int'(MIN_PER_DAY);
      best_idx  = 0;
      found     = 1'b0;
      for (int i = 0; i < N_PER_RELAY; i++) begin
        e = sched[cmd.relay_select * N_PER_RELAY + i];
        if (e.action != ACT_NONE) begin
          t_min = e.hour * MIN_PER_HOUR + e.minute;
          w     = (t_min + MIN_PER_DAY - now_min) % MIN_PER_DAY;
          if (w < best_wait) begin
            best_wait = w;
            best_idx  = i;
            found     = 1'b1;
          end
        end
      end

      rep              = '0;
      rep.relay_one_on = relay_on[0];
      rep.relay_two_on = relay_on[1];
      rep.clock_hour   = clk_hour;
      rep.clock_minute = clk_minute;
      rep.clock_second = clk_second;
      if (found) begin
        e               = sched[cmd.relay_select * N_PER_RELAY + best_idx];
        rep.next_found  = 1'b1;
        rep.next_index  = 3'(best_idx);
        rep.next_hour   = e.hour;
        rep.next_minute = e.minute;
        rep.next_wait   = 11'(best_wait);
      end
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [10:0] exp_v, logic [10:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, got_v);
        error_count++;
      end
    endfunction

    // compare one observed report with the oldest prediction
    function void check_result(out_t got);
      out_t exp_r;
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        error_count++;
        return;
      end
      exp_r = pending_reports.pop_front();
      compare_field("relay_one_on", 11'(exp_r.relay_one_on), 11'(got.relay_one_on));
      compare_field("relay_two_on", 11'(exp_r.relay_two_on), 11'(got.relay_two_on));
      compare_field("clock_hour", 11'(exp_r.clock_hour), 11'(got.clock_hour));
      compare_field("clock_minute", 11'(exp_r.clock_minute), 11'(got.clock_minute));
      compare_field("clock_second", 11'(exp_r.clock_second), 11'(got.clock_second));
      compare_field("next_found", 11'(exp_r.next_found), 11'(got.next_found));
      compare_field("next_index", 11'(exp_r.next_index), 11'(got.next_index));
      compare_field("next_hour", 11'(exp_r.next_hour), 11'(got.next_hour));
      compare_field("next_minute", 11'(exp_r.next_minute), 11'(got.next_minute));
      compare_field("next_wait", exp_r.next_wait, got.next_wait);
    endfunction

    function void flag_leftovers();
      foreach (pending_reports[i]) begin
        $display("%0t missing result: expected %h actual none", $time, pending_reports[i]);
        error_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  in_t  item;
  logic busy;
  logic done;
  out_t result;

  alarm_scoreboard sb;
  int              sent_count;
  int              burst_left;

  relay_alarm_scheduler_clock #(
    .ENTRIES_PER_RELAY(N_PER_RELAY)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the design hangs
  initial begin
    #2000000;
    $display("relay_alarm_scheduler_clock_test failed");
    $finish;
  end

  // results are present for exactly one cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic in_t make_cmd(logic [1:0] mode, logic relay, logic [2:0] idx,
                                   logic [1:0] act, logic [4:0] h, logic [5:0] m,
                                   logic [5:0] s);
    in_t c;
    c.mode         = mode;
    c.relay_select = relay;
    c.entry_index  = idx;
    c.entry_action = act;
    c.set_hour     = h;
    c.set_minute   = m;
    c.set_second   = s;
    return c;
  endfunction

  // mostly no idle gap, some short ones, a few long ones, and bursts with none
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_command(in_t cmd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= cmd;
    do @(posedge clk); while (busy);
    sb.note_command(cmd);
    sent_count++;
    @(negedge clk);
  endtask

  // arm one or two entries at a time, then tick toward that minute from just before it
  task automatic run_alarm_scenario();
    logic [4:0] th;
    logic [5:0] tm;
    logic       r;
    int         pre;
    int         ticks;
    th  = 5'($urandom_range(0, 23));
    tm  = 6'($urandom_range(0, 59));
    r   = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      th = '0;
      tm = '0;
    end
    send_command(make_cmd(MODE_WRITE, r, 3'($urandom_range(0, 4)),
                          2'($urandom_range(1, 2)), th, tm, 6'($urandom())));
    if ($urandom_range(0, 1))
      send_command(make_cmd(MODE_WRITE, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 4)),
                            2'($urandom_range(0, 3)), th, tm, 6'($urandom())));
    pre = (th * 60 + tm + 1439) % 1440;
    send_command(make_cmd(MODE_SET, 1'($urandom_range(0, 1)), 3'($urandom()), 2'($urandom()),
                          5'(pre / 60), 6'(pre % 60), 6'($urandom_range(45, 59))));
    ticks = $urandom_range(5, 25);
    repeat (ticks) begin
      if ($urandom_range(0, 7) == 0)
        send_command(make_cmd(MODE_QUERY, 1'($urandom_range(0, 1)), 3'($urandom()),
                              2'($urandom()), 5'($urandom()), 6'($urandom()),
                              6'($urandom())));
      else
        send_command(make_cmd(MODE_TICK, 1'($urandom_range(0, 1)), 3'($urandom()),
                              2'($urandom()), 5'($urandom()), 6'($urandom()),
                              6'($urandom())));
    end
  endtask

  initial begin
    int waited;
    sb         = new();
    sent_count = 0;
    burst_left = 0;
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset state, saturation, ignored writes, ties, last match wins
    send_command(make_cmd(MODE_QUERY, 1'b0, 3'd0, ACT_NONE, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_QUERY, 1'b1, 3'd7, ACT_BAD, 5'd31, 6'd63, 6'd63));
    send_command(make_cmd(MODE_WRITE, 1'b0, 3'd0, ACT_ON, 5'd31, 6'd63, 6'd0));
    send_command(make_cmd(MODE_WRITE, 1'b0, 3'd4, ACT_OFF, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_WRITE, 1'b0, 3'd5, ACT_ON, 5'd1, 6'd1, 6'd0));
    send_command(make_cmd(MODE_WRITE, 1'b1, 3'd7, ACT_ON, 5'd2, 6'd2, 6'd0));
    send_command(make_cmd(MODE_WRITE, 1'b1, 3'd2, ACT_BAD, 5'd12, 6'd0, 6'd0));
    send_command(make_cmd(MODE_WRITE, 1'b1, 3'd1, ACT_ON, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_WRITE, 1'b1, 3'd3, ACT_ON, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_WRITE, 1'b1, 3'd4, ACT_OFF, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_SET, 1'b1, 3'd0, ACT_NONE, 5'd31, 6'd63, 6'd63));
    send_command(make_cmd(MODE_SET, 1'b0, 3'd0, ACT_NONE, 5'd23, 6'd58, 6'd59));
    send_command(make_cmd(MODE_TICK, 1'b0, 3'd0, ACT_NONE, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_SET, 1'b1, 3'd0, ACT_NONE, 5'd23, 6'd59, 6'd59));
    send_command(make_cmd(MODE_TICK, 1'b1, 3'd0, ACT_NONE, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_WRITE, 1'b1, 3'd4, ACT_NONE, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_SET, 1'b0, 3'd0, ACT_NONE, 5'd23, 6'd59, 6'd59));
    send_command(make_cmd(MODE_TICK, 1'b1, 3'd7, ACT_BAD, 5'd31, 6'd63, 6'd63));
    send_command(make_cmd(MODE_TICK, 1'b0, 3'd0, ACT_NONE, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_QUERY, 1'b1, 3'd0, ACT_NONE, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_SET, 1'b0, 3'd0, ACT_NONE, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_WRITE, 1'b0, 3'd0, ACT_NONE, 5'd0, 6'd0, 6'd0));
    send_command(make_cmd(MODE_QUERY, 1'b0, 3'd0, ACT_NONE, 5'd0, 6'd0, 6'd0));

    // random: mostly armed alarm sequences, the rest raw noise
    while (sent_count < ITEM_GOAL + 23) begin
      if ($urandom_range(0, 99) < 60) begin
        run_alarm_scenario();
      end else begin
        repeat ($urandom_range(1, 5)) send_command(in_t'($urandom()));
      end
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending_reports.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    sb.flag_leftovers();
    if (sb.error_count == 0) begin
      $display("relay_alarm_scheduler_clock_test passed");
    end else begin
      $display("relay_alarm_scheduler_clock_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
